// ===== design/kmpa_pkg.sv =====
// kmpa_pkg: shared types and constants for the k-means pixel assign and update block
`timescale 1ns / 1ps
package kmpa_pkg;

   localparam int PIX_W       = 8;
   localparam int CEN_W       = 16;
   localparam int SUM_W       = 32;
   localparam int SQ_W        = 32;
   localparam int DIST_W      = 34;
   localparam int OUT_COUNT_W = 24;
   localparam int OUT_ID_W    = 6;
   localparam int OP_W        = 2;
   localparam int LOAD_IDX_W  = 6;
   localparam int ACT_W       = 7;
   localparam int NCH_W       = 3;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int PORT_CH     = 4;
   localparam int QUO_W       = 16;
   localparam int NUM_W       = SUM_W + 9;
   localparam int DIV_STEPS   = QUO_W;
   localparam int DIV_CNT_W   = 5;

   localparam logic [OP_W-1:0] OP_LOAD     = 2'd0;
   localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd1;
   localparam logic [OP_W-1:0] OP_UPDATE   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_CLUSTERS = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNELS_IN_USE = 4'd1;

   localparam logic [ACT_W-1:0] ACT_RESET = 7'd32;
   localparam logic [NCH_W-1:0] NCH_RESET = 3'd3;

   localparam logic KIND_CLASSIFY = 1'b0;
   localparam logic KIND_REPORT   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ACC_RD,
      ST_ACC_WR,
      ST_CLS_OUT,
      ST_UPD_RD,
      ST_UPD_DIV,
      ST_UPD_OUT
   } state_type;

   // control from the sequencer to every lane
   typedef struct packed {
      logic cent_vld_rd;
      logic acc_vld_rd;
      logic cent_we;
      logic cent_upd_sel;
      logic sum_we;
      logic div_load;
      logic div_step;
      logic cnt_nonzero;
   } lane_ctl_type;

endpackage

// ===== design/kmpa_lane.sv =====
// kmpa_lane: one channel lane with centroid and sum memories, squarer and divider
`timescale 1ns / 1ps
module kmpa_lane #(
   parameter int IW       = 6,
   parameter int CLUSTERS = 64,
   parameter int CNT_W    = 24
) (
   input  logic                        clock,
   input  kmpa_pkg::lane_ctl_type      ctl,
   input  logic                        in_use,
   input  logic [IW-1:0]               rd_addr,
   input  logic [IW-1:0]               cent_wr_addr,
   input  logic [IW-1:0]               sum_wr_addr,
   input  logic [kmpa_pkg::CEN_W-1:0]  load_data,
   input  logic [kmpa_pkg::PIX_W-1:0]  px,
   input  logic [CNT_W-1:0]            cnt,
   output logic [kmpa_pkg::SQ_W-1:0]   sq,
   output logic [kmpa_pkg::CEN_W-1:0]  upd_val
);
   import kmpa_pkg::*;

   logic [CEN_W-1:0] cent_mem [CLUSTERS];
   logic [SUM_W-1:0] sum_mem  [CLUSTERS];

   logic [CEN_W-1:0] cent_rd_ff;
   logic [SUM_W-1:0] sum_rd_ff;
   logic [CEN_W-1:0] cent_cur;
   logic [SUM_W-1:0] sum_cur;
   logic [CEN_W-1:0] px_fix;
   logic [CEN_W-1:0] mag;
   logic [SQ_W-1:0]  sq_ff;
   logic [SQ_W-1:0]  sq_in;
   logic [SUM_W:0]   sum_add;
   logic [SUM_W-1:0] sum_wr_data;
   logic [CEN_W-1:0] cent_wr_data;
   logic [NUM_W-1:0] num;
   logic [CNT_W:0]   rem_ff, rem_in, trial;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [QUO_W-1:0] nlow_ff, nlow_in;

   always_ff @(posedge clock) begin
      cent_rd_ff <= cent_mem[rd_addr];
      sum_rd_ff  <= sum_mem[rd_addr];
      if (ctl.cent_we) begin
         cent_mem[cent_wr_addr] <= cent_wr_data;
      end
      if (ctl.sum_we) begin
         sum_mem[sum_wr_addr] <= sum_wr_data;
      end
   end

   // entries never written read as zero
   assign cent_cur = ctl.cent_vld_rd ? cent_rd_ff : '0;
   assign sum_cur  = ctl.acc_vld_rd ? sum_rd_ff : '0;

   assign px_fix = {px, 8'h00};
   assign mag    = (px_fix >= cent_cur) ? (px_fix - cent_cur) : (cent_cur - px_fix);
   assign sq_in  = in_use ? (SQ_W'(mag) * SQ_W'(mag)) : '0;

   always_ff @(posedge clock) begin
      sq_ff <= sq_in;
   end
   assign sq = sq_ff;

   assign sum_add     = {1'b0, sum_cur} + (SUM_W + 1)'(px);
   assign sum_wr_data = !in_use ? sum_cur :
                        (sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0]);

   // restoring divide, quotient known to fit 16 bits
   assign num   = {1'b0, sum_cur, 8'h00} + NUM_W'(cnt >> 1);
   assign trial = {rem_ff[CNT_W-1:0], nlow_ff[QUO_W-1]};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      nlow_in = nlow_ff;
      if (ctl.div_load) begin
         rem_in  = (CNT_W + 1)'(num >> QUO_W);
         quo_in  = '0;
         nlow_in = num[QUO_W-1:0];
      end else if (ctl.div_step) begin
         nlow_in = {nlow_ff[QUO_W-2:0], 1'b0};
         if (trial >= {1'b0, cnt}) begin
            rem_in = trial - {1'b0, cnt};
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      nlow_ff <= nlow_in;
   end

   assign upd_val      = (ctl.cnt_nonzero && in_use) ? quo_ff : cent_cur;
   assign cent_wr_data = ctl.cent_upd_sel ? upd_val : load_data;

endmodule

// ===== design/kmpa_merge.sv =====
// kmpa_merge: adds lane squares into a distance and keeps the nearest centroid
`timescale 1ns / 1ps
module kmpa_merge #(
   parameter int NL = 4,
   parameter int IW = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [kmpa_pkg::SQ_W-1:0]  sq [NL],
   input  logic                       sq_vld,
   input  logic [IW-1:0]              sq_idx,
   output logic [IW-1:0]              best_idx,
   output logic                       busy
);
   import kmpa_pkg::*;

   logic [DIST_W-1:0] dist_in, dist_ff;
   logic              dist_vld_ff;
   logic [IW-1:0]     dist_idx_ff;
   logic [DIST_W-1:0] best_d_ff;
   logic [IW-1:0]     best_ff;

   always_comb begin
      dist_in = '0;
      for (int i = 0; i < NL; i++) begin
         dist_in = dist_in + DIST_W'(sq[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_vld_ff <= 1'b0;
      end else begin
         dist_vld_ff <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff     <= dist_in;
      dist_idx_ff <= sq_idx;
      // only a strictly smaller distance wins, so ties keep the lower index
      if (dist_vld_ff && (dist_idx_ff == '0 || dist_ff < best_d_ff)) begin
         best_d_ff <= dist_ff;
         best_ff   <= dist_idx_ff;
      end
   end

   assign best_idx = best_ff;
   assign busy     = dist_vld_ff;

endmodule

// ===== design/kmeans_pixel_assign_and_update.sv =====
// kmeans_pixel_assign_and_update: top level, sequencer, counts memory and result register
//
//  channel | ports                  | direction | handshake
//  --------+------------------------+-----------+--------------------
//  req     | op, index, pixel, load | in        | req_valid / req_stall
//  rsp     | kind, id, c0-c3, count | out       | rsp_valid / rsp_stall
//  csr     | index, data            | in        | csr_valid / csr_ready
//
// a load is written as the item is taken; classify reads one centroid per cycle from
// the lane memories, then does a read-modify-write of the chosen sums
// update reports one active cluster at a time, each after the 16-step lane dividers
// reset clears state and valid bits at once, no clearing pass
// a result waits in the output register while rsp_stall is high; the next item is
// still taken, the sequencer only holds when it needs the output register
`timescale 1ns / 1ps
module kmeans_pixel_assign_and_update #(
   parameter int MAX_CLUSTERS = 64,
   parameter int MAX_CHANNELS = 4,
   parameter int COUNT_BITS   = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [kmpa_pkg::OP_W-1:0]        req_op,
   input  logic [kmpa_pkg::LOAD_IDX_W-1:0]  req_load_index,
   input  logic [kmpa_pkg::PIX_W-1:0]       req_pixel_c0,
   input  logic [kmpa_pkg::PIX_W-1:0]       req_pixel_c1,
   input  logic [kmpa_pkg::PIX_W-1:0]       req_pixel_c2,
   input  logic [kmpa_pkg::PIX_W-1:0]       req_pixel_c3,
   input  logic [kmpa_pkg::CEN_W-1:0]       req_load_c0,
   input  logic [kmpa_pkg::CEN_W-1:0]       req_load_c1,
   input  logic [kmpa_pkg::CEN_W-1:0]       req_load_c2,
   input  logic [kmpa_pkg::CEN_W-1:0]       req_load_c3,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_result_kind,
   output logic [kmpa_pkg::OUT_ID_W-1:0]    rsp_cluster_id,
   output logic [kmpa_pkg::CEN_W-1:0]       rsp_out_c0,
   output logic [kmpa_pkg::CEN_W-1:0]       rsp_out_c1,
   output logic [kmpa_pkg::CEN_W-1:0]       rsp_out_c2,
   output logic [kmpa_pkg::CEN_W-1:0]       rsp_out_c3,
   output logic [kmpa_pkg::OUT_COUNT_W-1:0] rsp_member_count,
   output logic                             rsp_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [kmpa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [kmpa_pkg::CSR_DATA_W-1:0]  csr_data
);
   import kmpa_pkg::*;

   localparam int IW = $clog2(MAX_CLUSTERS);
   localparam int KW = $clog2(MAX_CLUSTERS + 1);

   state_type state_ff, state_in;

   logic [ACT_W-1:0]      act_ff;
   logic [NCH_W-1:0]      nch_ff;
   logic [KW-1:0]         k_eff;
   logic [NCH_W-1:0]      nch_eff;
   logic [IW-1:0]         cnt_ff, cnt_in;
   logic                  issue_ff, issue_in;
   logic                  s1_vld_ff, s2_vld_ff;
   logic [IW-1:0]         s1_idx_ff, s2_idx_ff;
   logic [DIV_CNT_W-1:0]  div_ff, div_in;
   logic [PIX_W-1:0]      px_ff [PORT_CH];
   logic [CEN_W-1:0]      load_data [PORT_CH];
   logic [MAX_CLUSTERS-1:0] cent_vld_ff, acc_vld_ff;
   logic                  cvld_rd_ff, avld_rd_ff;
   logic [COUNT_BITS-1:0] cnt_mem [MAX_CLUSTERS];
   logic [COUNT_BITS-1:0] cnt_rd_ff, cnt_cur;
   logic                  cnt_sat;
   logic                  is_last;
   logic                  accept;
   logic                  load_hit;
   logic                  out_free;
   logic                  out_load;
   logic                  cnt_we;
   logic                  acc_clear;
   logic [IW-1:0]         rd_addr;
   logic [IW-1:0]         cent_wr_addr;
   logic [IW-1:0]         best_idx;
   logic                  merge_busy;
   logic [MAX_CHANNELS-1:0] in_use;
   lane_ctl_type          ctl;
   logic [SQ_W-1:0]       lane_sq  [MAX_CHANNELS];
   logic [CEN_W-1:0]      lane_upd [MAX_CHANNELS];
   logic [CEN_W-1:0]      rep_c    [PORT_CH];

   logic                   out_vld_ff, out_vld_in;
   logic                   out_kind_ff, out_kind_in;
   logic [OUT_ID_W-1:0]    out_id_ff, out_id_in;
   logic [CEN_W-1:0]       out_c_ff [PORT_CH];
   logic [CEN_W-1:0]       out_c_in [PORT_CH];
   logic [OUT_COUNT_W-1:0] out_cnt_ff, out_cnt_in;
   logic                   out_last_ff, out_last_in;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= ACT_RESET;
         nch_ff <= NCH_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_ACTIVE_CLUSTERS: act_ff <= csr_data[ACT_W-1:0];
            REG_CHANNELS_IN_USE: nch_ff <= csr_data[NCH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (act_ff == '0) begin
         k_eff = KW'(1);
      end else if (int'(act_ff) > MAX_CLUSTERS) begin
         k_eff = KW'(MAX_CLUSTERS);
      end else begin
         k_eff = KW'(act_ff);
      end
      if (nch_ff == '0) begin
         nch_eff = NCH_W'(1);
      end else if (int'(nch_ff) > MAX_CHANNELS) begin
         nch_eff = NCH_W'(MAX_CHANNELS);
      end else begin
         nch_eff = nch_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         in_use[i] = (i < int'(nch_eff));
      end
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign load_hit  = accept && (req_op == OP_LOAD) && (int'(req_load_index) < MAX_CLUSTERS);
   assign out_free  = !out_vld_ff || !rsp_stall;
   assign is_last   = ((KW + 1)'(cnt_ff) + (KW + 1)'(1)) == (KW + 1)'(k_eff);
   assign cnt_cur   = avld_rd_ff ? cnt_rd_ff : '0;
   assign cnt_sat   = (cnt_cur == {COUNT_BITS{1'b1}});

   assign load_data[0] = req_load_c0;
   assign load_data[1] = req_load_c1;
   assign load_data[2] = req_load_c2;
   assign load_data[3] = req_load_c3;

   always_ff @(posedge clock) begin
      if (accept) begin
         px_ff[0] <= req_pixel_c0;
         px_ff[1] <= req_pixel_c1;
         px_ff[2] <= req_pixel_c2;
         px_ff[3] <= req_pixel_c3;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_op == OP_CLASSIFY) begin
               state_in = ST_SCAN;
            end else if (accept && req_op == OP_UPDATE) begin
               state_in = ST_UPD_RD;
            end
         end
         ST_SCAN: begin
            if (!issue_ff && !s1_vld_ff && !s2_vld_ff && !merge_busy) begin
               state_in = ST_ACC_RD;
            end
         end
         ST_ACC_RD:  state_in = ST_ACC_WR;
         ST_ACC_WR:  state_in = ST_CLS_OUT;
         ST_CLS_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_UPD_RD:  state_in = ST_UPD_DIV;
         ST_UPD_DIV: begin
            if (div_ff == DIV_CNT_W'(DIV_STEPS)) begin
               state_in = ST_UPD_OUT;
            end
         end
         ST_UPD_OUT: begin
            if (out_free) begin
               state_in = is_last ? ST_IDLE : ST_UPD_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      cnt_in       = cnt_ff;
      issue_in     = issue_ff;
      div_in       = '0;
      rd_addr      = cnt_ff;
      cent_wr_addr = cnt_ff;
      ctl          = '0;
      cnt_we       = 1'b0;
      acc_clear    = 1'b0;
      out_load     = 1'b0;
      out_kind_in  = KIND_CLASSIFY;
      out_id_in    = '0;
      out_cnt_in   = '0;
      out_last_in  = 1'b0;
      for (int j = 0; j < PORT_CH; j++) begin
         out_c_in[j] = '0;
      end
      ctl.cent_vld_rd = cvld_rd_ff;
      ctl.acc_vld_rd  = avld_rd_ff;
      ctl.cnt_nonzero = (cnt_cur != '0);
      case (state_ff)
         ST_IDLE: begin
            cent_wr_addr = IW'(req_load_index);
            ctl.cent_we  = load_hit;
            if (accept) begin
               cnt_in   = '0;
               issue_in = (req_op == OP_CLASSIFY);
            end
         end
         ST_SCAN: begin
            if (issue_ff) begin
               if (is_last) begin
                  issue_in = 1'b0;
               end else begin
                  cnt_in = cnt_ff + IW'(1);
               end
            end
         end
         ST_ACC_RD: begin
            rd_addr = best_idx;
         end
         ST_ACC_WR: begin
            rd_addr    = best_idx;
            ctl.sum_we = !cnt_sat;
            cnt_we     = !cnt_sat;
         end
         ST_CLS_OUT: begin
            out_load  = out_free;
            out_id_in = OUT_ID_W'(best_idx);
         end
         ST_UPD_RD: ;
         ST_UPD_DIV: begin
            div_in       = div_ff + DIV_CNT_W'(1);
            ctl.div_load = (div_ff == '0);
            ctl.div_step = (div_ff != '0);
         end
         ST_UPD_OUT: begin
            ctl.cent_upd_sel = 1'b1;
            ctl.cent_we      = out_free;
            out_load         = out_free;
            out_kind_in      = KIND_REPORT;
            out_id_in        = OUT_ID_W'(cnt_ff);
            out_cnt_in       = OUT_COUNT_W'(cnt_cur);
            out_last_in      = is_last;
            for (int j = 0; j < PORT_CH; j++) begin
               out_c_in[j] = rep_c[j];
            end
            if (out_free) begin
               if (is_last) begin
                  acc_clear = 1'b1;
               end else begin
                  cnt_in = cnt_ff + IW'(1);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         issue_ff    <= 1'b0;
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         div_ff      <= '0;
         cent_vld_ff <= '0;
         acc_vld_ff  <= '0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issue_ff  <= issue_in;
         s1_vld_ff <= (state_ff == ST_SCAN) && issue_ff;
         s2_vld_ff <= s1_vld_ff;
         div_ff    <= div_in;
         out_vld_ff <= out_vld_in;
         if (ctl.cent_we) begin
            cent_vld_ff[cent_wr_addr] <= 1'b1;
         end
         if (acc_clear) begin
            acc_vld_ff <= '0;
         end else if (cnt_we) begin
            acc_vld_ff[best_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      s1_idx_ff  <= cnt_ff;
      s2_idx_ff  <= s1_idx_ff;
      cvld_rd_ff <= cent_vld_ff[rd_addr];
      avld_rd_ff <= acc_vld_ff[rd_addr];
      cnt_rd_ff  <= cnt_mem[rd_addr];
      if (cnt_we) begin
         cnt_mem[best_idx] <= cnt_cur + COUNT_BITS'(1);
      end
   end

   // lanes, one per channel
   for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
      kmpa_lane #(
         .IW       (IW),
         .CLUSTERS (MAX_CLUSTERS),
         .CNT_W    (COUNT_BITS)
      ) u_lane (
         .clock        (clock),
         .ctl          (ctl),
         .in_use       (in_use[g]),
         .rd_addr      (rd_addr),
         .cent_wr_addr (cent_wr_addr),
         .sum_wr_addr  (best_idx),
         .load_data    (load_data[g]),
         .px           (px_ff[g]),
         .cnt          (cnt_cur),
         .sq           (lane_sq[g]),
         .upd_val      (lane_upd[g])
      );
   end

   for (genvar j = 0; j < PORT_CH; j++) begin : g_rep
      if (j < MAX_CHANNELS) begin : g_on
         assign rep_c[j] = in_use[j] ? lane_upd[j] : '0;
      end else begin : g_off
         assign rep_c[j] = '0;
      end
   end

   kmpa_merge #(
      .NL (MAX_CHANNELS),
      .IW (IW)
   ) u_merge (
      .clock    (clock),
      .reset    (reset),
      .sq       (lane_sq),
      .sq_vld   (s2_vld_ff),
      .sq_idx   (s2_idx_ff),
      .best_idx (best_idx),
      .busy     (merge_busy)
   );

   // result register
   always_comb begin
      if (out_load) begin
         out_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_kind_ff <= out_kind_in;
         out_id_ff   <= out_id_in;
         out_cnt_ff  <= out_cnt_in;
         out_last_ff <= out_last_in;
         for (int j = 0; j < PORT_CH; j++) begin
            out_c_ff[j] <= out_c_in[j];
         end
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_result_kind  = out_kind_ff;
   assign rsp_cluster_id   = out_id_ff;
   assign rsp_out_c0       = out_c_ff[0];
   assign rsp_out_c1       = out_c_ff[1];
   assign rsp_out_c2       = out_c_ff[2];
   assign rsp_out_c3       = out_c_ff[3];
   assign rsp_member_count = out_cnt_ff;
   assign rsp_last         = out_last_ff;

   a_last_is_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_result_kind == KIND_REPORT)
      else $error("last mark on a classification item");

   a_cls_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_CLASSIFY |->
         rsp_out_c0 == '0 && rsp_member_count == '0 && !rsp_last)
      else $error("classification item carries centroid data");

   a_scan_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ACC_RD |-> !s1_vld_ff && !s2_vld_ff && !merge_busy && !issue_ff)
      else $error("sums read before the distance scan finished");

   a_update_clears: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPD_OUT && out_free && is_last |=>
         state_ff == ST_IDLE && acc_vld_ff == '0)
      else $error("accumulators not cleared after the last report");

endmodule

// ===== bench/kmpa_checker.sv =====
// kmpa_checker: watches the item, result and register channels, predicts and compares results
`timescale 1ns / 1ps
module kmpa_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [kmpa_pkg::OP_W-1:0]           req_op,
   input  logic [kmpa_pkg::LOAD_IDX_W-1:0]     req_load_index,
   input  logic [kmpa_pkg::PIX_W-1:0]          req_pixel_c0,
   input  logic [kmpa_pkg::PIX_W-1:0]          req_pixel_c1,
   input  logic [kmpa_pkg::PIX_W-1:0]          req_pixel_c2,
   input  logic [kmpa_pkg::PIX_W-1:0]          req_pixel_c3,
   input  logic [kmpa_pkg::CEN_W-1:0]          req_load_c0,
   input  logic [kmpa_pkg::CEN_W-1:0]          req_load_c1,
   input  logic [kmpa_pkg::CEN_W-1:0]          req_load_c2,
   input  logic [kmpa_pkg::CEN_W-1:0]          req_load_c3,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic                                rsp_result_kind,
   input  logic [kmpa_pkg::OUT_ID_W-1:0]       rsp_cluster_id,
   input  logic [kmpa_pkg::CEN_W-1:0]          rsp_out_c0,
   input  logic [kmpa_pkg::CEN_W-1:0]          rsp_out_c1,
   input  logic [kmpa_pkg::CEN_W-1:0]          rsp_out_c2,
   input  logic [kmpa_pkg::CEN_W-1:0]          rsp_out_c3,
   input  logic [kmpa_pkg::OUT_COUNT_W-1:0]    rsp_member_count,
   input  logic                                rsp_last,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [kmpa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [kmpa_pkg::CSR_DATA_W-1:0]     csr_data,
   output int                                  mismatches,
   output int                                  pending
);
   import kmpa_pkg::*;

   localparam int NCLUST = 64;
   localparam int NCHAN  = 4;
   localparam longint unsigned COUNT_TOP = (64'd1 << OUT_COUNT_W) - 1;

   typedef struct packed {
      logic                      kind;
      logic [OUT_ID_W-1:0]       id;
      logic [3:0][CEN_W-1:0]     cen;
      logic [OUT_COUNT_W-1:0]    count;
      logic                      last;
   } cluster_result_type;

   cluster_result_type expected_results[$];

   logic [CEN_W-1:0]       centroids [NCLUST][NCHAN];
   logic [SUM_W-1:0]       sums      [NCLUST][NCHAN];
   logic [OUT_COUNT_W-1:0] members   [NCLUST];
   logic [ACT_W-1:0]       k_setting;
   logic [NCH_W-1:0]       nch_setting;

   function automatic int k_eff();
      if (k_setting == 0) return 1;
      if (k_setting > NCLUST) return NCLUST;
      return k_setting;
   endfunction

   function automatic int nch_eff();
      if (nch_setting == 0) return 1;
      if (nch_setting > NCHAN) return NCHAN;
      return nch_setting;
   endfunction

   task automatic clear_accumulators();
      for (int c = 0; c < NCLUST; c++) begin
         members[c] = '0;
         for (int ch = 0; ch < NCHAN; ch++) sums[c][ch] = '0;
      end
   endtask

   task automatic classify_pixel(input logic [3:0][PIX_W-1:0] px);
      int k, nch, best;
      longint unsigned d, best_d, s;
      longint diff;
      cluster_result_type r;
      k = k_eff();
      nch = nch_eff();
      best = 0;
      best_d = 0;
      for (int c = 0; c < k; c++) begin
         d = 0;
         for (int ch = 0; ch < nch; ch++) begin
            diff = longint'(px[ch]) * 256 - longint'(centroids[c][ch]);
            d += longint'(diff * diff);
         end
         if (c == 0 || d < best_d) begin
            best = c;
            best_d = d;
         end
      end
      // a saturated cluster still answers but stops accumulating
      if (members[best] < COUNT_TOP) begin
         for (int ch = 0; ch < nch; ch++) begin
            s = longint'(sums[best][ch]) + px[ch];
            if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
            sums[best][ch] = s[31:0];
         end
         members[best] = members[best] + 1'b1;
      end
      r = '0;
      r.kind = KIND_CLASSIFY;
      r.id = best[OUT_ID_W-1:0];
      expected_results.push_back(r);
   endtask

   task automatic update_centroids();
      int k, nch;
      longint unsigned cnt, q;
      cluster_result_type r;
      k = k_eff();
      nch = nch_eff();
      for (int c = 0; c < k; c++) begin
         cnt = members[c];
         // empty cluster keeps its old centroid
         if (cnt > 0) begin
            for (int ch = 0; ch < nch; ch++) begin
               q = (longint'(sums[c][ch]) * 256 + cnt / 2) / cnt;
               if (q > 64'hFFFF) q = 64'hFFFF;
               centroids[c][ch] = q[15:0];
            end
         end
         r = '0;
         r.kind = KIND_REPORT;
         r.id = c[OUT_ID_W-1:0];
         for (int ch = 0; ch < NCHAN; ch++) r.cen[ch] = (ch < nch) ? centroids[c][ch] : '0;
         r.count = cnt[OUT_COUNT_W-1:0];
         r.last = (c + 1 == k);
         expected_results.push_back(r);
      end
      clear_accumulators();
   endtask

   always @(posedge clock) begin
      cluster_result_type got, exp_r;
      if (reset) begin
         mismatches = 0;
         k_setting <= ACT_RESET;
         nch_setting <= NCH_RESET;
         for (int c = 0; c < NCLUST; c++)
            for (int ch = 0; ch < NCHAN; ch++) centroids[c][ch] = '0;
         clear_accumulators();
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.kind = rsp_result_kind;
            got.id = rsp_cluster_id;
            got.cen = {rsp_out_c3, rsp_out_c2, rsp_out_c1, rsp_out_c0};
            got.count = rsp_member_count;
            got.last = rsp_last;
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
               exp_r = expected_results.pop_front();
               if (got !== exp_r) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected kind %0d id %0d c %h count %0d last %0d,",
                               " got kind %0d id %0d c %h count %0d last %0d"},
                              exp_r.kind, exp_r.id, exp_r.cen, exp_r.count, exp_r.last,
                              got.kind, got.id, got.cen, got.count, got.last);
               end
            end
         end
         if (req_valid && !req_stall) begin
            case (req_op)
               OP_LOAD: begin
                  centroids[req_load_index][0] = req_load_c0;
                  centroids[req_load_index][1] = req_load_c1;
                  centroids[req_load_index][2] = req_load_c2;
                  centroids[req_load_index][3] = req_load_c3;
               end
               OP_CLASSIFY:
                  classify_pixel({req_pixel_c3, req_pixel_c2, req_pixel_c1, req_pixel_c0});
               OP_UPDATE: update_centroids();
               default: ;
            endcase
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_ACTIVE_CLUSTERS) k_setting <= csr_data[ACT_W-1:0];
            else if (csr_index == REG_CHANNELS_IN_USE) nch_setting <= csr_data[NCH_W-1:0];
         end
      end
      pending <= expected_results.size();
   end

endmodule

// ===== bench/tb_kmeans_pixel_assign_and_update.sv =====
// tb_kmeans_pixel_assign_and_update: stimulus, handshake pacing and verdict for the k-means block
`timescale 1ns / 1ps
module tb_kmeans_pixel_assign_and_update;
   import kmpa_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int RANDOM_ITEMS = 128;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [OP_W-1:0]        req_op;
   logic [LOAD_IDX_W-1:0]  req_load_index;
   logic [PIX_W-1:0]       req_pixel_c0, req_pixel_c1, req_pixel_c2, req_pixel_c3;
   logic [CEN_W-1:0]       req_load_c0, req_load_c1, req_load_c2, req_load_c3;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_result_kind;
   logic [OUT_ID_W-1:0]    rsp_cluster_id;
   logic [CEN_W-1:0]       rsp_out_c0, rsp_out_c1, rsp_out_c2, rsp_out_c3;
   logic [OUT_COUNT_W-1:0] rsp_member_count;
   logic                   rsp_last;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;
   int                     mismatches;
   int                     pending;
   int                     cycles;
   logic                   hold_req;
   logic                   hold_done;
   int                     burst_left;
   logic [PIX_W-1:0]       seeds [64][4];

   kmeans_pixel_assign_and_update uut (.*);

   kmpa_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver: changing stall pattern, plus one long hold-off on request
   initial begin
      int mode;
      rsp_stall = 1'b0;
      hold_done = 1'b0;
      mode = 0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            hold_done = 1'b1;
            rsp_stall <= 1'b0;
         end else begin
            if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 9) < 3);
               2: rsp_stall <= ($urandom_range(0, 9) < 7);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   task automatic send_item(input logic [OP_W-1:0] op, input logic [5:0] idx,
                            input logic [3:0][7:0] px, input logic [3:0][15:0] ld);
      req_valid <= 1'b1;
      req_op <= op;
      req_load_index <= idx;
      {req_pixel_c3, req_pixel_c2, req_pixel_c1, req_pixel_c0} <= px;
      {req_load_c3, req_load_c2, req_load_c1, req_load_c0} <= ld;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(0, 12);
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      // loads give no result, let the last one settle
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_seeded(input int idx);
      logic [3:0][15:0] ld;
      for (int ch = 0; ch < 4; ch++) begin
         seeds[idx][ch] = $urandom_range(0, 255);
         ld[ch] = {seeds[idx][ch], 8'($urandom_range(0, 255))};
      end
      send_item(OP_LOAD, idx[5:0], '0, ld);
   endtask

   task automatic classify_near(input int ncent);
      logic [3:0][7:0] px;
      int c, v;
      c = $urandom_range(0, ncent - 1);
      for (int ch = 0; ch < 4; ch++) begin
         v = int'(seeds[c][ch]) + $urandom_range(0, 40) - 20;
         px[ch] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
      end
      send_item(OP_CLASSIFY, 6'($urandom), px, 64'($urandom) << 32 | 64'($urandom));
   endtask

   initial begin
      int ks[8];
      int ns[8];
      int keff, pick, done_items;
      logic [3:0][15:0] ld;
      clock = 1'b0;
      reset = 1'b1;
      cycles = 0;
      hold_req = 1'b0;
      burst_left = 0;
      req_valid = 1'b0;
      req_op = OP_LOAD;
      req_load_index = '0;
      {req_pixel_c3, req_pixel_c2, req_pixel_c1, req_pixel_c0} = '0;
      {req_load_c3, req_load_c2, req_load_c1, req_load_c0} = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      for (int c = 0; c < 64; c++)
         for (int ch = 0; ch < 4; ch++) seeds[c][ch] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: all-zero store ties to cluster 0, extremes, unused op, empty update
      send_item(OP_CLASSIFY, '0, '0, '0);
      send_item(OP_CLASSIFY, '1, {4{8'hFF}}, {4{16'hFFFF}});
      send_item(OP_LOAD, 6'd63, '0, {4{16'hFFFF}});
      send_item(OP_LOAD, 6'd0, '0, '0);
      send_item(OP_LOAD, 6'd1, '0, '0);
      send_item(OP_LOAD, 6'd2, '0, {4{16'hFF00}});
      send_item(OP_CLASSIFY, '0, {4{8'hFF}}, '0);
      send_item(OP_CLASSIFY, '0, {4{8'h80}}, '0);
      send_item(OP_CLASSIFY, '0, '0, '0);
      send_item(OP_UNUSED, 6'h2A, {4{8'h55}}, {4{16'hAAAA}});
      send_item(OP_UPDATE, '0, '0, '0);
      send_item(OP_UPDATE, '0, '0, '0);
      drain();
      write_reg(REG_ACTIVE_CLUSTERS, 32'd64);
      write_reg(REG_CHANNELS_IN_USE, 32'd4);
      send_item(OP_CLASSIFY, '0, {4{8'hFF}}, '0);
      send_item(OP_CLASSIFY, '0, {8'h01, 8'h02, 8'h03, 8'h04}, '0);
      send_item(OP_UPDATE, '0, '0, '0);
      drain();

      // settings per phase, extremes and out-of-range values among them
      ks = '{4, 1, 64, 0, 127, 2, 8, 16};
      ns = '{4, 1, 4, 0, 7, 2, 3, 4};
      done_items = 0;
      for (int p = 0; p < 8; p++) begin
         drain();
         write_reg(REG_ACTIVE_CLUSTERS, (p == 3) ? 32'h0000_0180 : ks[p]);
         write_reg(REG_CHANNELS_IN_USE, ns[p]);
         keff = (ks[p] == 0) ? 1 : (ks[p] > 64) ? 64 : ks[p];
         for (int c = 0; c < keff; c++) load_seeded(c);
         if (p == 0) begin
            // long receiver hold while items keep coming, block must stall its input
            hold_req = 1'b1;
            for (int i = 0; i < 40; i++) classify_near(keff);
            send_item(OP_UPDATE, '0, '0, '0);
            drain();
         end
         for (int i = 0; i < RANDOM_ITEMS / 8; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) classify_near(keff);
            else if (pick < 80) begin
               send_item(OP_CLASSIFY, '0, 32'($urandom), '0);
            end else if (pick < 88) begin
               for (int ch = 0; ch < 4; ch++) ld[ch] = 16'($urandom);
               send_item(OP_LOAD, 6'($urandom), '0, ld);
            end else if (pick < 92) begin
               send_item(OP_UNUSED, 6'($urandom), 32'($urandom), '0);
            end else begin
               send_item(OP_UPDATE, '0, '0, '0);
            end
            done_items++;
         end
         send_item(OP_UPDATE, '0, '0, '0);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/kmpa_pkg.sv
design/kmpa_lane.sv
design/kmpa_merge.sv
design/kmeans_pixel_assign_and_update.sv
bench/kmpa_checker.sv
bench/tb_kmeans_pixel_assign_and_update.sv
